// ===== rtl/mse_pkg.sv =====
// shared types and constants of the multi-stage looping envelope
`default_nettype none

package mse_pkg;

  localparam int LEVEL_BITS     = 16;
  localparam int RATE_FRAC_BITS = 24;
  localparam int ACC_W          = LEVEL_BITS + RATE_FRAC_BITS;
  localparam int INC_W          = ACC_W + 1;

  localparam int TABLE_SIZE = 12;
  localparam int TBL_IDX_W  = $clog2(TABLE_SIZE);

  localparam int STAGE_W  = 4;
  localparam int REPEAT_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [STAGE_W-1:0] STAGE_IDLE    = STAGE_W'(0);
  localparam logic [STAGE_W-1:0] STAGE_FIRST   = STAGE_W'(1);
  localparam logic [STAGE_W-1:0] STAGE_MIN     = STAGE_W'(1);
  localparam logic [STAGE_W-1:0] STAGE_MAX     = STAGE_W'(10);
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = STAGE_W'(11);
  localparam logic [STAGE_W-1:0] LOOP_MIN_STEPS = STAGE_W'(2);

  localparam logic [TBL_IDX_W-1:0] ENTRY_START   = TBL_IDX_W'(0);
  localparam logic [TBL_IDX_W-1:0] ENTRY_RELEASE = TBL_IDX_W'(11);

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_NOTE_ON  = 2'd1,
    MODE_NOTE_OFF = 2'd2,
    MODE_TABLE_WR = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYPASS       = 3'd0,
    CFG_STAGE_COUNT  = 3'd1,
    CFG_LOOP_ENABLE  = 3'd2,
    CFG_LOOP_TARGET  = 3'd3,
    CFG_LOOP_REPEATS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    mode_e                     mode;
    logic [3:0]                entry_index;
    logic [LEVEL_BITS-1:0]     entry_level;
    logic [RATE_FRAC_BITS-1:0] entry_rate_recip;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  active;
    logic [STAGE_W-1:0]    stage;
  } out_item_t;

  // register values after clamping, as the envelope uses them
  typedef struct packed {
    logic                bypass;
    logic                loop_enable;
    logic [STAGE_W-1:0]  steps;
    logic [STAGE_W-1:0]  loop_to;
    logic [REPEAT_W-1:0] repeats;
  } eff_cfg_t;

  typedef struct packed {
    logic                      en;
    logic [3:0]                index;
    logic [LEVEL_BITS-1:0]     level;
    logic [RATE_FRAC_BITS-1:0] recip;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== rtl/multi_stage_looping_envelope_core.sv =====
// an accepted item is held in the input register; its result goes to the output register
// throughput: one item per cycle unless the output stalls; the state update (table
// read, 17x24 multiply, 41-bit add and compare) is combinational between the registers
// the output register lets the next item in while a result waits to be taken
// reset clears envelope state, whole table and config registers; stage count resets to 1
`default_nettype none

module multi_stage_looping_envelope_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire mse_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mse_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mse_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic                in_valid_q;
  mse_pkg::in_item_t   in_q;
  logic                out_valid_q;
  mse_pkg::out_item_t  out_q;

  logic                out_free;
  logic                proc_en;
  logic                accept;

  mse_pkg::eff_cfg_t   eff;
  mse_pkg::tbl_wr_t    tbl_wr;
  mse_pkg::out_item_t  result;

  logic [mse_pkg::LEVEL_BITS-1:0]     level_tbl [mse_pkg::TABLE_SIZE];
  logic [mse_pkg::RATE_FRAC_BITS-1:0] rate_tbl  [mse_pkg::TABLE_SIZE];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_en    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (proc_en) begin
        in_valid_q <= 1'b0;
      end
      if (proc_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (proc_en) begin
      out_q <= result;
    end
  end

  assign tbl_wr.en    = proc_en && (in_q.mode == mse_pkg::MODE_TABLE_WR);
  assign tbl_wr.index = in_q.entry_index;
  assign tbl_wr.level = in_q.entry_level;
  assign tbl_wr.recip = in_q.entry_rate_recip;

  mse_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .eff_o       (eff)
  );

  mse_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tbl_wr),
    .level_o (level_tbl),
    .rate_o  (rate_tbl)
  );

  mse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_en_i   (proc_en),
    .item_i      (in_q),
    .cfg_i       (eff),
    .level_tbl_i (level_tbl),
    .rate_tbl_i  (rate_tbl),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/mse_cfg.sv =====
// configuration registers and clamping of stage count and loop target
`default_nettype none

module mse_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [mse_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [mse_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output mse_pkg::eff_cfg_t                         eff_o
);

  logic                         bypass_q;
  logic [mse_pkg::STAGE_W-1:0]  stage_count_q;
  logic                         loop_enable_q;
  logic [mse_pkg::STAGE_W-1:0]  loop_target_q;
  logic [mse_pkg::REPEAT_W-1:0] loop_repeats_q;

  logic [mse_pkg::STAGE_W-1:0]  steps;
  logic [mse_pkg::STAGE_W-1:0]  loop_to;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q       <= 1'b0;
      stage_count_q  <= mse_pkg::STAGE_MIN;
      loop_enable_q  <= 1'b0;
      loop_target_q  <= '0;
      loop_repeats_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mse_pkg::cfg_idx_e'(cfg_index_i))
        mse_pkg::CFG_BYPASS:       bypass_q       <= cfg_data_i[0];
        mse_pkg::CFG_STAGE_COUNT:  stage_count_q  <= cfg_data_i[mse_pkg::STAGE_W-1:0];
        mse_pkg::CFG_LOOP_ENABLE:  loop_enable_q  <= cfg_data_i[0];
        mse_pkg::CFG_LOOP_TARGET:  loop_target_q  <= cfg_data_i[mse_pkg::STAGE_W-1:0];
        mse_pkg::CFG_LOOP_REPEATS: loop_repeats_q <= cfg_data_i[mse_pkg::REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    steps = stage_count_q;
    if (stage_count_q < mse_pkg::STAGE_MIN) begin
      steps = mse_pkg::STAGE_MIN;
    end else if (stage_count_q > mse_pkg::STAGE_MAX) begin
      steps = mse_pkg::STAGE_MAX;
    end
    if (loop_enable_q && steps < mse_pkg::LOOP_MIN_STEPS) begin
      steps = mse_pkg::LOOP_MIN_STEPS;
    end
    // with looping enabled, loop target stays at least two below the stage count
    loop_to = loop_target_q;
    if ({1'b0, loop_target_q} + {1'b0, mse_pkg::LOOP_MIN_STEPS} > {1'b0, steps}) begin
      loop_to = steps - mse_pkg::LOOP_MIN_STEPS;
    end
  end

  assign eff_o.bypass      = bypass_q;
  assign eff_o.loop_enable = loop_enable_q;
  assign eff_o.steps       = steps;
  assign eff_o.loop_to     = loop_to;
  assign eff_o.repeats     = loop_repeats_q;

endmodule

`default_nettype wire

// ===== rtl/mse_table.sv =====
// level and rate reciprocal table of the envelope stages
`default_nettype none

module mse_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mse_pkg::tbl_wr_t                    wr_i,
  output logic [mse_pkg::LEVEL_BITS-1:0]           level_o [mse_pkg::TABLE_SIZE],
  output logic [mse_pkg::RATE_FRAC_BITS-1:0]       rate_o  [mse_pkg::TABLE_SIZE]
);

  logic [mse_pkg::LEVEL_BITS-1:0]     level_q [mse_pkg::TABLE_SIZE];
  logic [mse_pkg::RATE_FRAC_BITS-1:0] rate_q  [mse_pkg::TABLE_SIZE];
  logic                               wr_hit;

  // writes beyond the last entry are dropped
  assign wr_hit = wr_i.en && ({1'b0, wr_i.index} < 5'(mse_pkg::TABLE_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mse_pkg::TABLE_SIZE; i++) begin
        level_q[i] <= '0;
        rate_q[i]  <= '0;
      end
    end else if (wr_hit) begin
      level_q[wr_i.index[mse_pkg::TBL_IDX_W-1:0]] <= wr_i.level;
      rate_q[wr_i.index[mse_pkg::TBL_IDX_W-1:0]]  <= wr_i.recip;
    end
  end

  assign level_o = level_q;
  assign rate_o  = rate_q;

endmodule

`default_nettype wire

// ===== rtl/mse_core.sv =====
// envelope state and its combinational next-state update for one item
`default_nettype none

module mse_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              proc_en_i,
  input  wire mse_pkg::in_item_t                 item_i,
  input  wire mse_pkg::eff_cfg_t                 cfg_i,
  input  wire logic [mse_pkg::LEVEL_BITS-1:0]     level_tbl_i [mse_pkg::TABLE_SIZE],
  input  wire logic [mse_pkg::RATE_FRAC_BITS-1:0] rate_tbl_i  [mse_pkg::TABLE_SIZE],
  output mse_pkg::out_item_t                     result_o
);

  localparam int LB  = mse_pkg::LEVEL_BITS;
  localparam int RB  = mse_pkg::RATE_FRAC_BITS;
  localparam int AW  = mse_pkg::ACC_W;
  localparam int IW  = mse_pkg::INC_W;
  localparam int SW  = mse_pkg::STAGE_W;
  localparam int XW  = mse_pkg::TBL_IDX_W;

  logic [AW-1:0]                  acc_q, acc_d;
  logic signed [IW-1:0]           inc_q, inc_d;
  logic [SW-1:0]                  stage_q, stage_d;
  logic [mse_pkg::REPEAT_W-1:0]   cnt_q, cnt_d;

  logic [LB-1:0]                  cur_lvl;
  logic                           lp;
  logic [SW-1:0]                  t_idx;
  logic [LB-1:0]                  t_lvl;
  logic [AW-1:0]                  t_acc;
  logic                           rate_zero;
  logic signed [AW+1:0]           sum;
  logic [AW-1:0]                  acc_adv;
  logic                           done;
  logic                           hit;
  logic [mse_pkg::REPEAT_W-1:0]   cnt_n;
  logic [SW-1:0]                  enter_s;
  logic [mse_pkg::REPEAT_W-1:0]   enter_cnt;
  logic                           enter_lp;
  logic [SW-1:0]                  e_tgt_idx;
  logic [SW-1:0]                  e_rate_idx;
  logic [LB-1:0]                  e_tgt;
  logic [RB-1:0]                  e_rate;
  logic [LB-1:0]                  base;
  logic signed [LB:0]             diff;
  logic signed [LB+RB+1:0]        prod;

  assign cur_lvl = acc_q[AW-1 -: LB];

  // reads of the target level and reciprocal of the running stage
  always_comb begin
    lp = cfg_i.loop_enable && (stage_q == cfg_i.steps) &&
         ((cfg_i.repeats == '0) || (cnt_q < cfg_i.repeats));
    if (stage_q == mse_pkg::STAGE_RELEASE) begin
      t_idx = mse_pkg::STAGE_RELEASE;
    end else if (lp) begin
      t_idx = cfg_i.loop_to;
    end else begin
      t_idx = stage_q;
    end
    t_lvl = ({1'b0, t_idx} < 5'(mse_pkg::TABLE_SIZE)) ? level_tbl_i[t_idx[XW-1:0]] : '0;
    t_acc = {t_lvl, {RB{1'b0}}};
    rate_zero = ({1'b0, stage_q} < 5'(mse_pkg::TABLE_SIZE)) ?
                (rate_tbl_i[stage_q[XW-1:0]] == '0) : 1'b1;
  end

  // one tick of the ramp with saturation and the reach test
  always_comb begin
    sum = $signed({2'b00, acc_q}) + $signed({inc_q[IW-1], inc_q});
    if (sum[AW+1]) begin
      acc_adv = '0;
    end else if (sum[AW]) begin
      acc_adv = '1;
    end else begin
      acc_adv = sum[AW-1:0];
    end
    done = inc_q[IW-1] ? (acc_adv <= t_acc) : (acc_adv >= t_acc);
    hit  = rate_zero || done;
  end

  // increment for the stage about to be entered
  always_comb begin
    cnt_n = (lp && (cfg_i.repeats != '0)) ? cnt_q + 1'b1 : cnt_q;
    if (item_i.mode == mse_pkg::MODE_NOTE_ON) begin
      enter_s   = mse_pkg::STAGE_FIRST;
      enter_cnt = '0;
    end else begin
      enter_s   = lp ? cfg_i.loop_to + 1'b1 : stage_q + 1'b1;
      enter_cnt = cnt_n;
    end
    enter_lp = cfg_i.loop_enable && (enter_s == cfg_i.steps) &&
               ((cfg_i.repeats == '0) || (enter_cnt < cfg_i.repeats));
    if (item_i.mode == mse_pkg::MODE_NOTE_OFF) begin
      e_tgt_idx  = mse_pkg::STAGE_RELEASE;
      e_rate_idx = mse_pkg::STAGE_RELEASE;
    end else begin
      e_tgt_idx  = enter_lp ? cfg_i.loop_to : enter_s;
      e_rate_idx = enter_s;
    end
    e_tgt  = ({1'b0, e_tgt_idx} < 5'(mse_pkg::TABLE_SIZE)) ?
             level_tbl_i[e_tgt_idx[XW-1:0]] : '0;
    e_rate = ({1'b0, e_rate_idx} < 5'(mse_pkg::TABLE_SIZE)) ?
             rate_tbl_i[e_rate_idx[XW-1:0]] : '0;
    if (item_i.mode == mse_pkg::MODE_NOTE_ON) begin
      base = level_tbl_i[mse_pkg::ENTRY_START];
    end else if (item_i.mode == mse_pkg::MODE_NOTE_OFF) begin
      base = cur_lvl;
    end else begin
      // a stage change starts from the snapped target level
      base = t_lvl;
    end
    diff = $signed({1'b0, e_tgt}) - $signed({1'b0, base});
    prod = diff * $signed({1'b0, e_rate});
  end

  always_comb begin
    acc_d   = acc_q;
    inc_d   = inc_q;
    stage_d = stage_q;
    cnt_d   = cnt_q;
    unique case (item_i.mode)
      mse_pkg::MODE_TICK: begin
        if (!cfg_i.bypass && stage_q != mse_pkg::STAGE_IDLE) begin
          acc_d = hit ? t_acc : acc_adv;
          if (stage_q == mse_pkg::STAGE_RELEASE) begin
            if (hit) begin
              stage_d = mse_pkg::STAGE_IDLE;
            end
          end else if (hit && (lp || cfg_i.steps > stage_q)) begin
            cnt_d   = cnt_n;
            stage_d = enter_s;
            inc_d   = prod[IW-1:0];
          end
        end
      end
      mse_pkg::MODE_NOTE_ON: begin
        cnt_d   = '0;
        acc_d   = {level_tbl_i[mse_pkg::ENTRY_START], {RB{1'b0}}};
        stage_d = mse_pkg::STAGE_FIRST;
        inc_d   = prod[IW-1:0];
      end
      mse_pkg::MODE_NOTE_OFF: begin
        stage_d = mse_pkg::STAGE_RELEASE;
        inc_d   = prod[IW-1:0];
      end
      mse_pkg::MODE_TABLE_WR: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      inc_q   <= '0;
      stage_q <= mse_pkg::STAGE_IDLE;
      cnt_q   <= '0;
    end else if (proc_en_i) begin
      acc_q   <= acc_d;
      inc_q   <= inc_d;
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
    end
  end

  assign result_o.level  = cfg_i.bypass ? {LB{1'b1}} : acc_d[AW-1 -: LB];
  assign result_o.active = (stage_d != mse_pkg::STAGE_IDLE);
  assign result_o.stage  = stage_d;

endmodule

`default_nettype wire
